// ===== src/sldq_pkg.sv =====
`timescale 1ns / 1ps

package sldq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W = 16;
  localparam int SIZE_W = 16;
  localparam int LIMIT_W = 24;
  localparam int TOTAL_W = 25;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_MODE = 1'd1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP = 1'b1;

  localparam logic [1:0] KIND_DROP = 2'd0;
  localparam logic [1:0] KIND_PUSH_DONE = 2'd1;
  localparam logic [1:0] KIND_POP = 2'd2;
  localparam logic [1:0] KIND_POP_EMPTY = 2'd3;

  typedef struct packed {
    logic              command;
    logic [TAG_W-1:0]  item_tag;
    logic [SIZE_W-1:0] item_size;
  } request_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [TAG_W-1:0]   out_tag;
    logic [SIZE_W-1:0]  out_size;
    logic [TOTAL_W-1:0] total_after;
    logic [CNT_W-1:0]   entries_after;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_EMPTY      = 3'd1,
    OP_POP        = 3'd2,
    OP_DROP       = 3'd3,
    OP_WRITE      = 3'd4,
    OP_WRITE_DONE = 3'd5,
    OP_DONE       = 3'd6
  } op_t;

  typedef struct packed {
    logic load;
    logic rd_head;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic over_new;
    logic drop_more;
    logic drop_from_head;
  } dp_status_t;

endpackage

// ===== src/sldq_ctrl.sv =====
`timescale 1ns / 1ps

module sldq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  input  sldq_pkg::dp_status_t status,
  output sldq_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_POP       = 6'b000010,
    S_FULL_DROP = 6'b000100,
    S_WRITE     = 6'b001000,
    S_CHECK     = 6'b010000,
    S_DROP_OUT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.load = 1'b0;
    cmd.rd_head = status.drop_from_head;
    cmd.op = sldq_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        // The memory read issued here serves the pop or the full-store drop.
        cmd.rd_head = (command == sldq_pkg::CMD_POP) || status.drop_from_head;
        if (start) begin
          cmd.load = 1'b1;
          if (command == sldq_pkg::CMD_POP) begin
            if (status.empty) begin
              cmd.op = sldq_pkg::OP_EMPTY;
            end else begin
              state_next = S_POP;
            end
          end else if (status.full) begin
            state_next = S_FULL_DROP;
          end else begin
            state_next = S_WRITE;
          end
        end
      end
      S_POP: begin
        cmd.op = sldq_pkg::OP_POP;
        state_next = S_IDLE;
      end
      S_FULL_DROP: begin
        cmd.op = sldq_pkg::OP_DROP;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (status.over_new) begin
          cmd.op = sldq_pkg::OP_WRITE;
          state_next = S_CHECK;
        end else begin
          cmd.op = sldq_pkg::OP_WRITE_DONE;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (status.drop_more) begin
          state_next = S_DROP_OUT;
        end else begin
          cmd.op = sldq_pkg::OP_DONE;
          state_next = S_IDLE;
        end
      end
      S_DROP_OUT: begin
        cmd.op = sldq_pkg::OP_DROP;
        state_next = S_CHECK;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/sldq_dp.sv =====
`timescale 1ns / 1ps

module sldq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sldq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sldq_pkg::LIMIT_W-1:0]        cfg_data,
  input  sldq_pkg::request_t                  request,
  input  sldq_pkg::dp_cmd_t                   cmd,
  output sldq_pkg::dp_status_t                status,
  output sldq_pkg::result_t                   result,
  output logic                                result_valid
);

  logic [sldq_pkg::TAG_W-1:0]   tag_mem [sldq_pkg::QUEUE_DEPTH];
  logic [sldq_pkg::SIZE_W-1:0]  size_mem [sldq_pkg::QUEUE_DEPTH];
  logic [sldq_pkg::TAG_W-1:0]   rd_tag;
  logic [sldq_pkg::SIZE_W-1:0]  rd_size;
  logic [sldq_pkg::PTR_W-1:0]   head;
  logic [sldq_pkg::PTR_W-1:0]   tail;
  logic [sldq_pkg::CNT_W-1:0]   count;
  logic [sldq_pkg::CNT_W-1:0]   drops;
  logic [sldq_pkg::TOTAL_W-1:0] total;
  logic [sldq_pkg::TAG_W-1:0]   lat_tag;
  logic [sldq_pkg::SIZE_W-1:0]  lat_size;
  logic [sldq_pkg::LIMIT_W-1:0] size_limit;
  logic                         drop_from_head;

  logic [sldq_pkg::PTR_W-1:0]   head_inc;
  logic [sldq_pkg::PTR_W-1:0]   tail_inc;
  logic [sldq_pkg::PTR_W-1:0]   tail_prev;
  logic [sldq_pkg::PTR_W-1:0]   rd_addr;
  logic [sldq_pkg::TOTAL_W-1:0] total_add;
  logic [sldq_pkg::TOTAL_W-1:0] total_sub;
  logic [sldq_pkg::TOTAL_W-1:0] limit_ext;

  localparam logic [sldq_pkg::PTR_W-1:0] LastSlot = sldq_pkg::PTR_W'(sldq_pkg::QUEUE_DEPTH - 1);
  localparam logic [sldq_pkg::CNT_W-1:0] DepthCnt = sldq_pkg::CNT_W'(sldq_pkg::QUEUE_DEPTH);

  assign head_inc  = (head == LastSlot) ? '0 : head + 1'b1;
  assign tail_inc  = (tail == LastSlot) ? '0 : tail + 1'b1;
  assign tail_prev = (tail == '0) ? LastSlot : tail - 1'b1;
  assign rd_addr   = cmd.rd_head ? head : tail_prev;
  assign total_add = total + sldq_pkg::TOTAL_W'(lat_size);
  assign total_sub = total - sldq_pkg::TOTAL_W'(rd_size);
  assign limit_ext = sldq_pkg::TOTAL_W'(size_limit);

  assign status.empty = (count == '0);
  assign status.full = (count >= DepthCnt);
  assign status.over_new = (total_add > limit_ext);
  assign status.drop_more = (total > limit_ext) && (count != '0) && (drops < DepthCnt);
  assign status.drop_from_head = drop_from_head;

  // Entry stores: one write port at the tail, one registered read port.
  always_ff @(posedge clk) begin
    rd_tag  <= tag_mem[rd_addr];
    rd_size <= size_mem[rd_addr];
    if (cmd.op == sldq_pkg::OP_WRITE || cmd.op == sldq_pkg::OP_WRITE_DONE) begin
      tag_mem[tail]  <= lat_tag;
      size_mem[tail] <= lat_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= '1;
      drop_from_head <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sldq_pkg::CFG_SIZE_LIMIT: size_limit <= cfg_data;
        sldq_pkg::CFG_DROP_MODE:  drop_from_head <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_tag  <= request.item_tag;
      lat_size <= request.item_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      total <= '0;
      drops <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.load) begin
        drops <= '0;
      end
      case (cmd.op)
        sldq_pkg::OP_EMPTY: begin
          result_valid <= 1'b1;
          result <= '{sldq_pkg::KIND_POP_EMPTY, '0, '0, total, count, 1'b1};
        end
        sldq_pkg::OP_POP: begin
          head <= head_inc;
          count <= count - 1'b1;
          total <= total_sub;
          result_valid <= 1'b1;
          result <= '{sldq_pkg::KIND_POP, rd_tag, rd_size, total_sub, count - 1'b1, 1'b1};
        end
        sldq_pkg::OP_DROP: begin
          if (drop_from_head) begin
            head <= head_inc;
          end else begin
            tail <= tail_prev;
          end
          count <= count - 1'b1;
          total <= total_sub;
          drops <= drops + 1'b1;
          result_valid <= 1'b1;
          result <= '{sldq_pkg::KIND_DROP, rd_tag, rd_size, total_sub, count - 1'b1, 1'b0};
        end
        sldq_pkg::OP_WRITE: begin
          tail <= tail_inc;
          count <= count + 1'b1;
          total <= total_add;
        end
        sldq_pkg::OP_WRITE_DONE: begin
          tail <= tail_inc;
          count <= count + 1'b1;
          total <= total_add;
          result_valid <= 1'b1;
          result <= '{sldq_pkg::KIND_PUSH_DONE, '0, '0, total_add, count + 1'b1, 1'b1};
        end
        sldq_pkg::OP_DONE: begin
          result_valid <= 1'b1;
          result <= '{sldq_pkg::KIND_PUSH_DONE, '0, '0, total, count, 1'b1};
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/size_limited_drop_queue.sv =====
`timescale 1ns / 1ps

// Packet queue whose fill is counted in size units, with drop-tail or
// drop-head policy. Commands arrive on request and are taken at an edge where
// start is high and busy is low; command 0 pushes item_tag/item_size, command
// 1 pops the head item.
// Results appear on result for one cycle each, marked by result_valid; the
// receiver cannot stall them. The last result of a command has last set.
// A push that drops nothing gives one result, registered in the write state.
// Each drop adds a drop result, and each drop of a burst waits in the check
// state for the registered read of the entry store.
// A pop waits in the pop state for the registered read; an empty-queue pop
// reports without raising busy. busy falls as the final result is presented.
// Configuration: cfg_we with cfg_index 0 writes size_limit, index 1 writes
// drop_from_head (bit 0 of cfg_data); write only while busy is low.
// Synchronous reset empties the queue, sets the limit to all ones and selects
// drop at the tail. The entry stores need no clearing after reset.
module size_limited_drop_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  sldq_pkg::request_t             request,
  output sldq_pkg::result_t              result,
  output logic                           result_valid,
  input  logic                           cfg_we,
  input  logic [sldq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sldq_pkg::LIMIT_W-1:0]   cfg_data
);

  sldq_pkg::dp_cmd_t    cmd;
  sldq_pkg::dp_status_t status;

  sldq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  sldq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .request      (request),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid)
  );

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last |-> !busy)
    else $error("final result shown while still busy");

  a_drop_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy && result.result_kind == sldq_pkg::KIND_DROP)
    else $error("non-final result that is not a drop");

  a_entries_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.entries_after <= sldq_pkg::CNT_W'(sldq_pkg::QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_accept_one_gap: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == sldq_pkg::CMD_PUSH |=> busy)
    else $error("push accepted without the block going busy");

endmodule
